// File: hw/rtl/rhwf_pkg.sv
package rhwf_pkg;

	localparam int DEF_GRID_WIDTH  = 32;
	localparam int DEF_GRID_HEIGHT = 32;
	localparam int DEF_STEP_FACTOR = 16;

	localparam int COORD_W = 5;

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STEP  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_ENT_ROW  = 2'd0;
	localparam logic [1:0] CFG_ENT_COL  = 2'd1;
	localparam logic [1:0] CFG_EXIT_ROW = 2'd2;
	localparam logic [1:0] CFG_EXIT_COL = 2'd3;

	// headings
	localparam logic [1:0] HEAD_RIGHT = 2'd0;
	localparam logic [1:0] HEAD_DOWN  = 2'd1;
	localparam logic [1:0] HEAD_LEFT  = 2'd2;
	localparam logic [1:0] HEAD_UP    = 2'd3;

	typedef enum logic [2:0] {
		ST_WALKING = 3'd0,
		ST_EXIT    = 3'd1,
		ST_BOXED   = 3'd2,
		ST_LIMIT   = 3'd3,
		ST_IDLE    = 3'd4
	} walk_status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_PROBE,
		CS_CHECK,
		CS_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic       wr;
		logic       start;
		logic       rd;
		logic       move;
		logic       boxed;
		logic       emit;
		logic [1:0] try_idx;
	} rhwf_cmd_t;

	typedef struct packed {
		logic walking;
		logic inb;
		logic wall;
		logic out_full;
	} rhwf_sts_t;

	// turn offset for try order: right, straight, left, back
	function automatic logic [1:0] turn_off(input logic [1:0] try_idx);
		logic [1:0] t;
		case (try_idx)
			2'd0:    t = 2'd1;
			2'd1:    t = 2'd0;
			2'd2:    t = 2'd3;
			default: t = 2'd2;
		endcase
		return t;
	endfunction

endpackage

// File: hw/rtl/rhwf_ctrl.sv
module rhwf_ctrl
	import rhwf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_req_type,
	output logic       in_ready,
	output rhwf_cmd_t  cmd,
	input  rhwf_sts_t  sts
);

	ctrl_state_t state_q, state_nx;
	logic [1:0]  try_q;
	logic        try_clr, try_inc;
	logic        accept;

	assign accept = in_valid && in_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (accept) begin
					unique case (in_req_type)
						REQ_WRITE: state_nx = CS_IDLE;
						REQ_START: state_nx = CS_EMIT;
						REQ_STEP:  state_nx = sts.walking ? CS_PROBE : CS_EMIT;
						default:   state_nx = CS_IDLE;
					endcase
				end
			end
			CS_PROBE: begin
				if (sts.inb) begin
					state_nx = CS_CHECK;
				end else if (try_q == 2'd3) begin
					state_nx = CS_EMIT;
				end
			end
			CS_CHECK: begin
				if (!sts.wall || try_q == 2'd3) begin
					state_nx = CS_EMIT;
				end else begin
					state_nx = CS_PROBE;
				end
			end
			CS_EMIT: begin
				if (!sts.out_full) begin
					state_nx = CS_IDLE;
				end
			end
			default: state_nx = CS_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.try_idx = try_q;
		try_clr     = 1'b0;
		try_inc     = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready  = 1'b1;
				try_clr   = 1'b1;
				cmd.wr    = in_valid && in_req_type == REQ_WRITE;
				cmd.start = in_valid && in_req_type == REQ_START;
			end
			CS_PROBE: begin
				if (sts.inb) begin
					cmd.rd = 1'b1;
				end else if (try_q == 2'd3) begin
					cmd.boxed = 1'b1;
				end else begin
					try_inc = 1'b1;
				end
			end
			CS_CHECK: begin
				if (!sts.wall) begin
					cmd.move = 1'b1;
				end else if (try_q == 2'd3) begin
					cmd.boxed = 1'b1;
				end else begin
					try_inc = 1'b1;
				end
			end
			CS_EMIT: begin
				cmd.emit = !sts.out_full;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			try_q   <= 2'd0;
		end else begin
			state_q <= state_nx;
			if (try_clr) begin
				try_q <= 2'd0;
			end else if (try_inc) begin
				try_q <= try_q + 2'd1;
			end
		end
	end

endmodule

// File: hw/rtl/rhwf_dp.sv
module rhwf_dp
	import rhwf_pkg::*;
#(
	parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
	parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
	parameter int STEP_FACTOR = DEF_STEP_FACTOR
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [COORD_W-1:0] cfg_data,
	input  logic [COORD_W-1:0] cell_row,
	input  logic [COORD_W-1:0] cell_col,
	input  logic               cell_wall,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [COORD_W-1:0] pos_row,
	output logic [COORD_W-1:0] pos_col,
	output logic [1:0]         heading,
	output logic [2:0]         status,
	input  rhwf_cmd_t          cmd,
	output rhwf_sts_t          sts
);

	localparam int RAW   = $clog2(GRID_HEIGHT);
	localparam int CAW   = $clog2(GRID_WIDTH);
	localparam int RW    = (RAW > COORD_W) ? RAW : COORD_W;
	localparam int CW    = (CAW > COORD_W) ? CAW : COORD_W;
	localparam int AW    = RAW + CAW;
	localparam int LIMIT = GRID_WIDTH * GRID_HEIGHT * STEP_FACTOR;
	localparam int CNTW  = $clog2(LIMIT + 1);

	logic [COORD_W-1:0] ent_row_q, ent_col_q, exit_row_q, exit_col_q;
	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic [1:0]         head_q;
	logic [CNTW-1:0]    cnt_q;
	walk_status_t       phase_q;

	logic               mem_q [2**AW];
	logic               rd_q;
	logic [AW-1:0]      addr;

	logic [1:0]         dir;
	logic [RW:0]        nr;
	logic [CW:0]        nc;
	logic [RW-1:0]      ent_row_x, cell_row_x;
	logic [CW-1:0]      ent_col_x, cell_col_x;
	logic               w_inb;
	logic [CNTW-1:0]    cnt_nx;
	logic               nx_at_exit, ent_at_exit;
	logic [1:0]         start_head;

	logic               out_valid_q;
	logic [COORD_W-1:0] out_row_q, out_col_q;
	logic [1:0]         out_head_q;
	logic [2:0]         out_stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_row_q  <= '0;
			ent_col_q  <= '0;
			exit_row_q <= '0;
			exit_col_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ENT_ROW:  ent_row_q  <= cfg_data;
				CFG_ENT_COL:  ent_col_q  <= cfg_data;
				CFG_EXIT_ROW: exit_row_q <= cfg_data;
				CFG_EXIT_COL: exit_col_q <= cfg_data;
				default:      ent_row_q  <= ent_row_q;
			endcase
		end
	end

	// neighbor of the current try
	always_comb begin
		dir = head_q + turn_off(cmd.try_idx);
		nr  = {1'b0, row_q};
		nc  = {1'b0, col_q};
		case (dir)
			HEAD_RIGHT: nc = {1'b0, col_q} + (CW+1)'(1);
			HEAD_DOWN:  nr = {1'b0, row_q} + (RW+1)'(1);
			HEAD_LEFT:  nc = {1'b0, col_q} - (CW+1)'(1);
			default:    nr = {1'b0, row_q} - (RW+1)'(1);
		endcase
	end

	// an underflow wraps to all ones and fails the bound test
	assign sts.inb = (nr < (RW+1)'(GRID_HEIGHT)) && (nc < (CW+1)'(GRID_WIDTH));

	assign cell_row_x = RW'(cell_row);
	assign cell_col_x = CW'(cell_col);
	assign w_inb      = ({1'b0, cell_row_x} < (RW+1)'(GRID_HEIGHT)) &&
	                    ({1'b0, cell_col_x} < (CW+1)'(GRID_WIDTH));

	assign addr = cmd.wr ? {cell_row_x[RAW-1:0], cell_col_x[CAW-1:0]}
	                     : {nr[RAW-1:0], nc[CAW-1:0]};

	// single-port wall memory
	always_ff @(posedge clk) begin
		if (cmd.wr && w_inb) begin
			mem_q[addr] <= cell_wall;
		end else if (cmd.rd) begin
			rd_q <= mem_q[addr];
		end
	end

	assign sts.wall     = rd_q;
	assign sts.walking  = phase_q == ST_WALKING;
	assign sts.out_full = out_valid_q && !out_ready;

	assign ent_row_x   = RW'(ent_row_q);
	assign ent_col_x   = CW'(ent_col_q);
	assign ent_at_exit = ent_row_q == exit_row_q && ent_col_q == exit_col_q;
	assign nx_at_exit  = nr[RW-1:0] == RW'(exit_row_q) && nc[CW-1:0] == CW'(exit_col_q);
	assign cnt_nx      = cnt_q + CNTW'(1);

	always_comb begin
		if (ent_row_q == '0) begin
			start_head = HEAD_DOWN;
		end else if (ent_row_x == RW'(GRID_HEIGHT - 1)) begin
			start_head = HEAD_UP;
		end else if (ent_col_q == '0) begin
			start_head = HEAD_RIGHT;
		end else begin
			start_head = HEAD_LEFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			head_q  <= HEAD_RIGHT;
			cnt_q   <= '0;
			phase_q <= ST_IDLE;
		end else if (cmd.start) begin
			row_q   <= ent_row_x;
			col_q   <= ent_col_x;
			head_q  <= start_head;
			cnt_q   <= '0;
			phase_q <= ent_at_exit ? ST_EXIT : ST_WALKING;
		end else if (cmd.move) begin
			row_q  <= nr[RW-1:0];
			col_q  <= nc[CW-1:0];
			head_q <= dir;
			cnt_q  <= cnt_nx;
			// exit wins over the limit on the last allowed move
			if (nx_at_exit) begin
				phase_q <= ST_EXIT;
			end else if (cnt_nx >= CNTW'(LIMIT)) begin
				phase_q <= ST_LIMIT;
			end
		end else if (cmd.boxed) begin
			phase_q <= ST_BOXED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_row_q  <= row_q[COORD_W-1:0];
			out_col_q  <= col_q[COORD_W-1:0];
			out_head_q <= head_q;
			out_stat_q <= phase_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_row   = out_row_q;
	assign pos_col   = out_col_q;
	assign heading   = out_head_q;
	assign status    = out_stat_q;

endmodule

// File: hw/rtl/right_hand_wall_follower_top.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    req_type, cell_row, cell_col, cell_wall
// out      out_valid / out_ready  pos_row, pos_col, heading, status
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A write is done in idle; a start goes from idle to emit. A step goes to emit when the walk
// is over; else it tries up to four neighbors, each with a bound test in probe and, when in
// bounds, a read of the single-port wall memory that is checked for a wall in check.
// Reset clears the walker, configuration and control; the wall memory is not cleared.
// A new item is taken while a result waits in the output register; a further start or step
// holds in its last cycle until that result is taken. cfg_ready is always high.
module right_hand_wall_follower_top
	import rhwf_pkg::*;
#(
	parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
	parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
	parameter int STEP_FACTOR = DEF_STEP_FACTOR
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [COORD_W-1:0] cell_row,
	input  logic [COORD_W-1:0] cell_col,
	input  logic               cell_wall,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] pos_row,
	output logic [COORD_W-1:0] pos_col,
	output logic [1:0]         heading,
	output logic [2:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [COORD_W-1:0] cfg_data
);

	rhwf_cmd_t cmd;
	rhwf_sts_t sts;

	assign cfg_ready = 1'b1;

	rhwf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_req_type (req_type),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	rhwf_dp #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT),
		.STEP_FACTOR (STEP_FACTOR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cell_row  (cell_row),
		.cell_col  (cell_col),
		.cell_wall (cell_wall),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.pos_row   (pos_row),
		.pos_col   (pos_col),
		.heading   (heading),
		.status    (status),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTH
	a_move_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> (sts.inb && !sts.wall))
		else $error("move into a wall or off the grid");

	a_probe_walking: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> sts.walking)
		else $error("neighbor read while the walk is over");

	a_idle_step_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type == REQ_STEP && !sts.walking)
		|=> (cmd.emit || sts.out_full))
		else $error("step after the walk ended did not go to the result");
`endif

endmodule
